// ----- sv/mpd_pkg.sv -----
// Shared types and codes for the MQTT PUBLISH deframer.
// No dependencies; imported by every module of the block.
package mpd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_TOPIC   = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // End-marker status codes
  localparam logic [1:0] ST_DELIVERED = 2'd0;
  localparam logic [1:0] ST_PING      = 2'd1;
  localparam logic [1:0] ST_IGNORED   = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

  // Header class of the current chunk
  localparam logic [1:0] CLS_NONE    = 2'd0;
  localparam logic [1:0] CLS_PUBLISH = 2'd1;
  localparam logic [1:0] CLS_PING    = 2'd2;
  localparam logic [1:0] CLS_OTHER   = 2'd3;

  // Fixed header fields
  localparam logic [7:0] TYPE_MASK     = 8'hF0;
  localparam logic [7:0] QOS_MASK      = 8'h06;
  localparam logic [7:0] TYPE_PUBLISH  = 8'h30;
  localparam logic [7:0] TYPE_PINGRESP = 8'hD0;

  // Depth of the command queue between front and back
  localparam int unsigned FifoDepth = 4;

  // One classified input byte: up to one data result plus an optional end marker.
  // Snapshot fields are shared by both results of the beat.
  typedef struct packed {
    logic        has_data;
    logic [1:0]  data_kind;
    logic [7:0]  data;
    logic        has_end;
    logic [1:0]  status;
    logic [1:0]  qos;
    logic [15:0] pay_len;
    logic [27:0] rem_len;
  } mpd_entry_t;

endpackage

// ----- sv/mpd_front.sv -----
// Front end: parses the byte stream and classifies each byte into a queue entry.
// Depends on mpd_pkg.
module mpd_front import mpd_pkg::*; #(
  parameter int unsigned MaxTopic = 64,
  parameter int unsigned ChunkMax = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  input  logic       chunk_end_i,
  output logic       wr_en_o,
  output mpd_entry_t entry_o
);

  localparam int unsigned CntW = $clog2(ChunkMax + 1);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_TLEN_HI = 3'd2;
  localparam logic [2:0] PH_TLEN_LO = 3'd3;
  localparam logic [2:0] PH_TOPIC   = 3'd4;
  localparam logic [2:0] PH_PKTID   = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;
  localparam logic [2:0] PH_IGNORE  = 3'd7;

  logic [2:0]      phase_q, phase_d;
  logic [27:0]     len_q, len_d;
  logic [2:0]      len_cnt_q, len_cnt_d;
  logic [15:0]     ttot_q, ttot_d;
  logic [15:0]     tseen_q, tseen_d;
  logic [1:0]      qos_q, qos_d;
  logic [1:0]      idskip_q, idskip_d;
  logic [15:0]     pay_q, pay_d;
  logic [1:0]      cls_q, cls_d;
  logic [CntW-1:0] chunk_q, chunk_d;

  logic        emit_data;
  logic [1:0]  emit_kind;
  logic [27:0] len_add;
  logic [2:0]  after_topic;
  logic [1:0]  status;

  assign after_topic = (qos_q != 2'd0) ? PH_PKTID : PH_PAYLOAD;

  always_comb begin
    unique case (len_cnt_q[1:0])
      2'd0:    len_add = {21'd0, rx_byte_i[6:0]};
      2'd1:    len_add = {14'd0, rx_byte_i[6:0], 7'd0};
      2'd2:    len_add = {7'd0, rx_byte_i[6:0], 14'd0};
      default: len_add = {rx_byte_i[6:0], 21'd0};
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    len_cnt_d = len_cnt_q;
    ttot_d    = ttot_q;
    tseen_d   = tseen_q;
    qos_d     = qos_q;
    idskip_d  = idskip_q;
    pay_d     = pay_q;
    cls_d     = cls_q;
    chunk_d   = chunk_q;
    emit_data = 1'b0;
    emit_kind = KIND_TOPIC;

    // bytes past the chunk limit change nothing
    if (chunk_q < CntW'(ChunkMax)) begin
      chunk_d = chunk_q + 1'b1;
      unique case (phase_q)
        PH_HEADER: begin
          qos_d = 2'((rx_byte_i & QOS_MASK) >> 1);
          if ((rx_byte_i & TYPE_MASK) == TYPE_PUBLISH) begin
            cls_d   = CLS_PUBLISH;
            phase_d = PH_LEN;
          end else if ((rx_byte_i & TYPE_MASK) == TYPE_PINGRESP) begin
            cls_d   = CLS_PING;
            phase_d = PH_IGNORE;
          end else begin
            cls_d   = CLS_OTHER;
            phase_d = PH_IGNORE;
          end
        end
        PH_LEN: begin
          if (len_cnt_q < 3'd4) begin
            len_d     = len_q + len_add;
            len_cnt_d = len_cnt_q + 3'd1;
          end
          if (!rx_byte_i[7]) phase_d = PH_TLEN_HI;
        end
        PH_TLEN_HI: begin
          ttot_d  = {rx_byte_i, 8'h00};
          phase_d = PH_TLEN_LO;
        end
        PH_TLEN_LO: begin
          ttot_d   = {ttot_q[15:8], rx_byte_i};
          tseen_d  = 16'd0;
          idskip_d = 2'd0;
          phase_d  = ({ttot_q[15:8], rx_byte_i} != 16'd0) ? PH_TOPIC : after_topic;
        end
        PH_TOPIC: begin
          if (tseen_q < 16'(MaxTopic - 1)) emit_data = 1'b1;
          tseen_d = tseen_q + 16'd1;
          if ((tseen_q + 16'd1) >= ttot_q) phase_d = after_topic;
        end
        PH_PKTID: begin
          idskip_d = idskip_q + 2'd1;
          if ((idskip_q + 2'd1) >= 2'd2) phase_d = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          pay_d     = pay_q + 16'd1;
          emit_data = 1'b1;
          emit_kind = KIND_PAYLOAD;
        end
        default: ;
      endcase
    end

    priority if (cls_d == CLS_PING) begin
      status = ST_PING;
    end else if (cls_d == CLS_PUBLISH) begin
      status = (phase_d == PH_PAYLOAD) ? ST_DELIVERED : ST_TRUNC;
    end else begin
      status = ST_IGNORED;
    end

    entry_o.has_data  = emit_data;
    entry_o.data_kind = emit_kind;
    entry_o.data      = rx_byte_i;
    entry_o.has_end   = chunk_end_i;
    entry_o.status    = status;
    entry_o.qos       = qos_d;
    entry_o.pay_len   = pay_d;
    entry_o.rem_len   = len_d;

    // end of chunk: back to header phase
    if (chunk_end_i) begin
      phase_d   = PH_HEADER;
      len_d     = '0;
      len_cnt_d = '0;
      ttot_d    = '0;
      tseen_d   = '0;
      qos_d     = '0;
      idskip_d  = '0;
      pay_d     = '0;
      cls_d     = CLS_NONE;
      chunk_d   = '0;
    end
  end

  assign wr_en_o = accept_i & (emit_data | chunk_end_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      len_q     <= '0;
      len_cnt_q <= '0;
      ttot_q    <= '0;
      tseen_q   <= '0;
      qos_q     <= '0;
      idskip_q  <= '0;
      pay_q     <= '0;
      cls_q     <= CLS_NONE;
      chunk_q   <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      len_q     <= len_d;
      len_cnt_q <= len_cnt_d;
      ttot_q    <= ttot_d;
      tseen_q   <= tseen_d;
      qos_q     <= qos_d;
      idskip_q  <= idskip_d;
      pay_q     <= pay_d;
      cls_q     <= cls_d;
      chunk_q   <= chunk_d;
    end
  end

endmodule

// ----- sv/mpd_fifo.sv -----
// Short command queue between the parsing front end and the result back end.
// Depends on mpd_pkg.
module mpd_fifo import mpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  mpd_entry_t wr_entry_i,
  output logic       full_o,
  input  logic       rd_en_i,
  output logic       rd_valid_o,
  output mpd_entry_t rd_entry_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  mpd_entry_t      mem_q [FifoDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o     = (cnt_q == CntW'(FifoDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_entry_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wptr_q] <= wr_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_en_i) wptr_q <= (wptr_q == PtrW'(FifoDepth - 1)) ? '0 : wptr_q + 1'b1;
      if (rd_en_i) rptr_q <= (rptr_q == PtrW'(FifoDepth - 1)) ? '0 : rptr_q + 1'b1;
      cnt_q <= cnt_q + CntW'(wr_en_i) - CntW'(rd_en_i);
    end
  end

endmodule

// ----- sv/mpd_back.sv -----
// Back end: expands queue entries into result beats held in an output register.
// Depends on mpd_pkg.
module mpd_back import mpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  mpd_entry_t  head_i,
  output logic        fifo_pop_o,
  input  logic        pop_i,
  output logic        out_valid_o,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_o,
  output logic [1:0]  status_o,
  output logic [1:0]  qos_level_o,
  output logic [15:0] payload_length_o,
  output logic [27:0] remaining_length_o,
  output logic        is_final_o
);

  logic        out_valid_q, out_valid_d;
  logic        half_q, half_d;
  logic        load, take_data;
  logic [1:0]  kind_q, status_q, qos_q;
  logic [7:0]  data_q;
  logic [15:0] pay_q;
  logic [27:0] len_q;
  logic        fin_q;

  assign load      = head_valid_i & (~out_valid_q | pop_i);
  assign take_data = head_i.has_data & ~half_q;

  always_comb begin
    out_valid_d = out_valid_q;
    half_d      = half_q;
    fifo_pop_o  = 1'b0;
    if (load) begin
      out_valid_d = 1'b1;
      if (take_data && head_i.has_end) begin
        half_d = 1'b1;
      end else begin
        half_d     = 1'b0;
        fifo_pop_o = 1'b1;
      end
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      half_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      half_q      <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      qos_q <= head_i.qos;
      pay_q <= head_i.pay_len;
      len_q <= head_i.rem_len;
      if (take_data) begin
        kind_q   <= head_i.data_kind;
        data_q   <= head_i.data;
        status_q <= ST_DELIVERED;
        fin_q    <= 1'b0;
      end else begin
        kind_q   <= KIND_END;
        data_q   <= 8'h00;
        status_q <= head_i.status;
        fin_q    <= 1'b1;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign kind_o             = kind_q;
  assign data_o             = data_q;
  assign status_o           = status_q;
  assign qos_level_o        = qos_q;
  assign payload_length_o   = pay_q;
  assign remaining_length_o = len_q;
  assign is_final_o         = fin_q;

  // split entry stays at the queue head until its end marker goes out
  a_half_holds_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |-> head_valid_i && head_i.has_end)
    else $error("split entry lost from queue head");

  a_half_after_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(half_q) |-> out_valid_q && !fin_q)
    else $error("split started without a data beat");

  a_final_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && fin_q |-> kind_q == KIND_END && data_q == 8'h00)
    else $error("final beat is not a clean end marker");

  a_pop_needs_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop_o |-> head_valid_i && (!out_valid_q || pop_i))
    else $error("queue popped without loading a beat");

endmodule

// ----- sv/mqtt_publish_deframer_top.sv -----
// MQTT PUBLISH deframer: one received byte per beat in, topic/payload/end beats out.
// A result passes through the command queue and the output register to the ports; an
// end marker sharing its byte with a data beat follows that beat. Reset (rst_ni low,
// async) clears parser, queue and output valid flag. Throughput: one byte per cycle
// while the queue is not full; the 4-entry queue absorbs a two-result byte's second beat.
// Depends on mpd_pkg, mpd_front, mpd_fifo, mpd_back.
module mqtt_publish_deframer_top import mpd_pkg::*; #(
  parameter int unsigned MaxTopic = 64,   // topic bytes emitted: at most MaxTopic-1
  parameter int unsigned ChunkMax = 256   // bytes of a chunk that are parsed
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  input  logic        chunk_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_o,
  output logic [1:0]  status_o,
  output logic [1:0]  qos_level_o,
  output logic [15:0] payload_length_o,
  output logic [27:0] remaining_length_o,
  output logic        is_final_o
);

  logic       accept;       // input beat taken this cycle
  logic       wr_en;        // front pushes a classified entry
  mpd_entry_t wr_entry;
  logic       fifo_full;
  logic       head_valid;
  mpd_entry_t head;
  logic       fifo_pop;
  logic       out_valid;
  logic       out_pop;      // result beat taken this cycle

  // The front stalls only when the command queue is full.
  assign full    = fifo_full;
  assign accept  = push & ~fifo_full;
  assign empty   = ~out_valid;
  assign out_pop = pop & out_valid;

  // Parser: header, remaining length, topic length, topic, packet id, payload.
  mpd_front #(
    .MaxTopic (MaxTopic),
    .ChunkMax (ChunkMax)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .chunk_end_i (chunk_end_i),
    .wr_en_o     (wr_en),
    .entry_o     (wr_entry)
  );

  // Decouples the parser from output back-pressure.
  mpd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_entry_i (wr_entry),
    .full_o     (fifo_full),
    .rd_en_i    (fifo_pop),
    .rd_valid_o (head_valid),
    .rd_entry_o (head)
  );

  // Turns each entry into one or two result beats.
  mpd_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_valid_i       (head_valid),
    .head_i             (head),
    .fifo_pop_o         (fifo_pop),
    .pop_i              (out_pop),
    .out_valid_o        (out_valid),
    .kind_o             (kind_o),
    .data_o             (data_o),
    .status_o           (status_o),
    .qos_level_o        (qos_level_o),
    .payload_length_o   (payload_length_o),
    .remaining_length_o (remaining_length_o),
    .is_final_o         (is_final_o)
  );

endmodule
